@@ src/mask_region_membership_test_top_defines.svh @@
// ----------------------------------------------------------------------------
// mask region membership test: assertion macros
// shared helpers for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef MASK_REGION_MEMBERSHIP_TEST_TOP_DEFINES_SVH
`define MASK_REGION_MEMBERSHIP_TEST_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define MRMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define MRMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mrmt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrmt_pkg
// widths, codes and the shape configuration type of the mask region test
// ----------------------------------------------------------------------------
`default_nettype none

package mrmt_pkg;

	localparam int COORD_BITS = 24;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int D_BITS     = COORD_BITS + 1;
	localparam int B_BITS     = COORD_BITS + 2;
	localparam int SQ_BITS    = 2 * D_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int RSQ_BITS   = 2 * RAD_BITS;

	localparam int DATA_BITS  = 32;
	localparam int ADDR_BITS  = 5;
	localparam int IDX_BITS   = ADDR_BITS - 2;

	localparam int MODE_BITS  = 2;
	localparam int OP_BITS    = 2;

	localparam logic [MODE_BITS-1:0] MODE_RECT   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_CIRCLE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_DONUT  = 2'd2;

	localparam logic [OP_BITS-1:0] OP_POINT_IN = 2'd0;
	localparam logic [OP_BITS-1:0] OP_BOX_IN   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_BOX_OUT  = 2'd2;

	localparam logic [IDX_BITS-1:0] REG_SHAPE_MODE   = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_REF_X        = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_REF_Y        = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_RECT_HIGH_X  = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_RECT_HIGH_Y  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_OUTER_RAD    = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_INNER_RAD    = 3'd6;

	typedef struct packed {
		logic [MODE_BITS-1:0]  shape_mode;
		logic [COORD_BITS-1:0] ref_x;
		logic [COORD_BITS-1:0] ref_y;
		logic [COORD_BITS-1:0] rect_high_x;
		logic [COORD_BITS-1:0] rect_high_y;
		logic [RAD_BITS-1:0]   outer_rad;
		logic [RAD_BITS-1:0]   inner_rad;
	} cfg_t;

endpackage

`default_nettype wire

@@ src/mask_region_membership_test_top.sv @@
// ----------------------------------------------------------------------------
// mask_region_membership_test_top
// point and box tests against a rectangle, circle or doughnut mask
// ----------------------------------------------------------------------------
// Each request asks whether a point lies inside the mask shape, whether a box
// lies fully inside it, or whether a box lies outside it; the single answer
// bit is presented from the stage-four output register, in request order.
// One request is taken every cycle while the output side keeps up; the rate
// is set by the four-stage pipeline (bounds and distances, squares, corner
// compares, answer select), and stall on the input rises only when all four
// stages hold a request and the output is stalled. Coordinates are signed
// Q12.12. Shape registers sit on the APB port at byte offsets 0x00 to 0x18
// and may only be changed while no request is in flight.
`default_nettype none

module mask_region_membership_test_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mrmt_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [mrmt_pkg::DATA_BITS-1:0]  pwdata,
	output logic [mrmt_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mrmt_pkg::OP_BITS-1:0]    op,
	input  logic [mrmt_pkg::COORD_BITS-1:0] first_x,
	input  logic [mrmt_pkg::COORD_BITS-1:0] first_y,
	input  logic [mrmt_pkg::COORD_BITS-1:0] second_x,
	input  logic [mrmt_pkg::COORD_BITS-1:0] second_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            answer
);
	import mrmt_pkg::*;

	cfg_t                cfg_q;
	logic [IDX_BITS-1:0] idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SHAPE_MODE:  cfg_q.shape_mode  <= pwdata[MODE_BITS-1:0];
				REG_REF_X:       cfg_q.ref_x       <= pwdata[COORD_BITS-1:0];
				REG_REF_Y:       cfg_q.ref_y       <= pwdata[COORD_BITS-1:0];
				REG_RECT_HIGH_X: cfg_q.rect_high_x <= pwdata[COORD_BITS-1:0];
				REG_RECT_HIGH_Y: cfg_q.rect_high_y <= pwdata[COORD_BITS-1:0];
				REG_OUTER_RAD:   cfg_q.outer_rad   <= pwdata[RAD_BITS-1:0];
				REG_INNER_RAD:   cfg_q.inner_rad   <= pwdata[RAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SHAPE_MODE:  prdata = DATA_BITS'(cfg_q.shape_mode);
			REG_REF_X:       prdata = DATA_BITS'($signed(cfg_q.ref_x));
			REG_REF_Y:       prdata = DATA_BITS'($signed(cfg_q.ref_y));
			REG_RECT_HIGH_X: prdata = DATA_BITS'($signed(cfg_q.rect_high_x));
			REG_RECT_HIGH_Y: prdata = DATA_BITS'($signed(cfg_q.rect_high_y));
			REG_OUTER_RAD:   prdata = DATA_BITS'(cfg_q.outer_rad);
			REG_INNER_RAD:   prdata = DATA_BITS'(cfg_q.inner_rad);
			default:         prdata = '0;
		endcase
	end

	mrmt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.answer    (answer)
	);

endmodule

`default_nettype wire

@@ src/mrmt_core.sv @@
// ----------------------------------------------------------------------------
// mrmt_core
// four-stage test pipeline: distances and bounds, squares, corner compares,
// answer select
// ----------------------------------------------------------------------------
`default_nettype none

`include "mask_region_membership_test_top_defines.svh"

module mrmt_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrmt_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mrmt_pkg::OP_BITS-1:0]    op,
	input  logic [mrmt_pkg::COORD_BITS-1:0] first_x,
	input  logic [mrmt_pkg::COORD_BITS-1:0] first_y,
	input  logic [mrmt_pkg::COORD_BITS-1:0] second_x,
	input  logic [mrmt_pkg::COORD_BITS-1:0] second_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            answer
);
	import mrmt_pkg::*;

	function automatic logic signed [B_BITS-1:0] bext(input logic [COORD_BITS-1:0] a);
		bext = B_BITS'($signed(a));
	endfunction

	function automatic logic [D_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		logic signed [D_BITS-1:0] d;
		d = D_BITS'($signed(a)) - D_BITS'($signed(b));
		abs_diff = d[D_BITS-1] ? D_BITS'(-d) : D_BITS'(d);
	endfunction

	// handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !valid_s4 || !out_stall;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: distances to centre, rectangle and bounding box compares
	logic signed [B_BITS-1:0] lx, ly, hx, hy, rx, ry, tx, ty;
	logic signed [B_BITS-1:0] ro, ri;
	logic                     rect_lo_c, rect_hi_c, rect_out_c, out_o_c, out_i_c;

	always_comb begin
		lx = bext(first_x);
		ly = bext(first_y);
		hx = bext(second_x);
		hy = bext(second_y);
		rx = bext(cfg.ref_x);
		ry = bext(cfg.ref_y);
		tx = bext(cfg.rect_high_x);
		ty = bext(cfg.rect_high_y);
		ro = B_BITS'(cfg.outer_rad);
		ri = B_BITS'(cfg.inner_rad);
		rect_lo_c  = (lx >= rx) && (lx <= tx) && (ly >= ry) && (ly <= ty);
		rect_hi_c  = (hx >= rx) && (hx <= tx) && (hy >= ry) && (hy <= ty);
		rect_out_c = (lx > tx) || (ly > ty) || (hx < rx) || (hy < ry);
		out_o_c    = (lx > rx + ro) || (ly > ry + ro) || (hx < rx - ro) || (hy < ry - ro);
		out_i_c    = (lx > rx + ri) || (ly > ry + ri) || (hx < rx - ri) || (hy < ry - ri);
	end

	logic [OP_BITS-1:0] op_s1;
	logic [D_BITS-1:0]  mlx_s1, mhx_s1, mly_s1, mhy_s1;
	logic               rect_lo_s1, rect_hi_s1, rect_out_s1, out_o_s1, out_i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			op_s1       <= op;
			mlx_s1      <= abs_diff(first_x, cfg.ref_x);
			mhx_s1      <= abs_diff(second_x, cfg.ref_x);
			mly_s1      <= abs_diff(first_y, cfg.ref_y);
			mhy_s1      <= abs_diff(second_y, cfg.ref_y);
			rect_lo_s1  <= rect_lo_c;
			rect_hi_s1  <= rect_hi_c;
			rect_out_s1 <= rect_out_c;
			out_o_s1    <= out_o_c;
			out_i_s1    <= out_i_c;
		end
	end

	// stage 2: squares
	logic [OP_BITS-1:0]  op_s2;
	logic [SQ_BITS-1:0]  sqlx_s2, sqhx_s2, sqly_s2, sqhy_s2;
	logic [RSQ_BITS-1:0] osq_s2, isq_s2;
	logic                rect_lo_s2, rect_hi_s2, rect_out_s2, out_o_s2, out_i_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			op_s2       <= op_s1;
			sqlx_s2     <= SQ_BITS'(mlx_s1) * SQ_BITS'(mlx_s1);
			sqhx_s2     <= SQ_BITS'(mhx_s1) * SQ_BITS'(mhx_s1);
			sqly_s2     <= SQ_BITS'(mly_s1) * SQ_BITS'(mly_s1);
			sqhy_s2     <= SQ_BITS'(mhy_s1) * SQ_BITS'(mhy_s1);
			osq_s2      <= RSQ_BITS'(cfg.outer_rad) * RSQ_BITS'(cfg.outer_rad);
			isq_s2      <= RSQ_BITS'(cfg.inner_rad) * RSQ_BITS'(cfg.inner_rad);
			rect_lo_s2  <= rect_lo_s1;
			rect_hi_s2  <= rect_hi_s1;
			rect_out_s2 <= rect_out_s1;
			out_o_s2    <= out_o_s1;
			out_i_s2    <= out_i_s1;
		end
	end

	// stage 3: corner distance sums against both radii
	// corners: low-low, high-high, low x high y, high x low y
	logic [SUM_BITS-1:0] csum [4];
	logic [3:0]          co_c, ci_c;

	always_comb begin
		csum[0] = SUM_BITS'(sqlx_s2) + SUM_BITS'(sqly_s2);
		csum[1] = SUM_BITS'(sqhx_s2) + SUM_BITS'(sqhy_s2);
		csum[2] = SUM_BITS'(sqlx_s2) + SUM_BITS'(sqhy_s2);
		csum[3] = SUM_BITS'(sqhx_s2) + SUM_BITS'(sqly_s2);
		for (int k = 0; k < 4; k++) begin
			co_c[k] = csum[k] <= SUM_BITS'(osq_s2);
			ci_c[k] = csum[k] <= SUM_BITS'(isq_s2);
		end
	end

	logic [OP_BITS-1:0] op_s3;
	logic [3:0]         co_s3, ci_s3;
	logic               rect_lo_s3, rect_hi_s3, rect_out_s3, out_o_s3, out_i_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			op_s3       <= op_s2;
			co_s3       <= co_c;
			ci_s3       <= ci_c;
			rect_lo_s3  <= rect_lo_s2;
			rect_hi_s3  <= rect_hi_s2;
			rect_out_s3 <= rect_out_s2;
			out_o_s3    <= out_o_s2;
			out_i_s3    <= out_i_s2;
		end
	end

	// stage 4: answer select, output register
	logic ans_c;

	always_comb begin
		ans_c = 1'b0;
		case (cfg.shape_mode)
			MODE_RECT: begin
				case (op_s3)
					OP_POINT_IN: ans_c = rect_lo_s3;
					OP_BOX_IN:   ans_c = rect_lo_s3 && rect_hi_s3;
					OP_BOX_OUT:  ans_c = rect_out_s3;
					default:     ans_c = 1'b0;
				endcase
			end
			MODE_CIRCLE: begin
				case (op_s3)
					OP_POINT_IN: ans_c = co_s3[0];
					OP_BOX_IN:   ans_c = &co_s3;
					OP_BOX_OUT:  ans_c = out_o_s3;
					default:     ans_c = 1'b0;
				endcase
			end
			MODE_DONUT: begin
				case (op_s3)
					OP_POINT_IN: ans_c = co_s3[0] && !ci_s3[0];
					OP_BOX_IN:   ans_c = (&co_s3) && out_i_s3;
					OP_BOX_OUT:  ans_c = out_o_s3 || (&ci_s3);
					default:     ans_c = 1'b0;
				endcase
			end
			default: ans_c = 1'b0;
		endcase
	end

	logic answer_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			answer_s4 <= ans_c;
		end
	end

	assign out_valid = valid_s4;
	assign answer    = answer_s4;

	`MRMT_ASSERT_NOW(a_stall_only_when_full, in_stall,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall,
		"input stalled while the pipeline has room")
	`MRMT_ASSERT_NEXT(a_request_enters_s1, in_valid && !in_stall, valid_s1,
		"accepted request did not reach stage one")
	`MRMT_ASSERT_NEXT(a_s3_moves_to_out, valid_s3 && rdy_s4, valid_s4,
		"request lost between stage three and the output register")
	`MRMT_ASSERT_NOW(a_inner_within_outer,
		valid_s3 && ci_s3[0] && (cfg.inner_rad <= cfg.outer_rad), co_s3[0],
		"point inside inner circle but outside a larger outer circle")

endmodule

`default_nettype wire
